// ===== rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types, constants and helper functions for the echo ranger core.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

    // Width of the microsecond delay and timeout counters.
    localparam int TIMER_BITS = 24;
    // Width of the configuration registers.
    localparam int CFG_W      = 24;
    // Width of the configuration register index.
    localparam int CFG_IDX_W  = 2;
    // Width of the echo time reading.
    localparam int ECHO_W     = 16;

    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [CFG_W-1:0]      t_cfg_word;
    typedef logic [ECHO_W-1:0]     t_echo;

    localparam t_timer TIMER_MAX  = '1;
    localparam t_echo  NO_READING = 16'hFFFF;
    localparam t_echo  WIDTH_MAX  = 16'hFFFE;

    localparam t_cfg_word TRIGGER_TIME_RST = 24'd2000;
    localparam t_cfg_word TIMEOUT_RST      = 24'd100000;
    localparam t_cfg_word REPEAT_GAP_RST   = 24'd1000000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_TIME = 2'd0,
        CFG_TIMEOUT      = 2'd1,
        CFG_REPEAT_GAP   = 2'd2
    } t_cfg_idx;

    // Measurement phase. Codes outside the list behave as trigger start.
    typedef enum logic [2:0] {
        PH_TRIG_START = 3'd0,
        PH_TRIG_STOP  = 3'd1,
        PH_WAIT_HIGH  = 3'd2,
        PH_WAIT_LOW   = 3'd3
    } t_phase;

    // Current configuration register contents.
    typedef struct packed {
        t_cfg_word trigger_time_us;
        t_cfg_word timeout_us;
        t_cfg_word repeat_gap_us;
    } t_cfg;

    // One result transaction as produced by the control logic.
    typedef struct packed {
        logic  trigger_level;
        t_echo echo_time_us;
        logic  new_reading;
    } t_result;

    // Load a register value into a timer counter, saturating it when the
    // counter is narrower than the register.
    function automatic t_timer load_count(input t_cfg_word v);
        logic [31:0] v32;
        logic [31:0] m32;
        begin
            v32 = 32'(v);
            m32 = 32'(TIMER_MAX);
            return (v32 > m32) ? TIMER_BITS'(m32) : TIMER_BITS'(v32);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uer_if.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger channel interfaces
// Valid/ready channels for input samples, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_in_if import uer_pkg::*;;
    logic valid;
    logic ready;
    logic tick;
    logic echo_level;

    modport source (output valid, output tick, output echo_level, input ready);
    modport sink   (input valid, input tick, input echo_level, output ready);
endinterface

interface uer_out_if import uer_pkg::*;;
    logic  valid;
    logic  ready;
    logic  trigger_level;
    t_echo echo_time_us;
    logic  new_reading;

    modport source (output valid, output trigger_level, output echo_time_us,
                    output new_reading, input ready);
    modport sink   (input valid, input trigger_level, input echo_time_us,
                    input new_reading, output ready);
endinterface

interface uer_cfg_if import uer_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_cfg_word            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_core.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Trigger pulse generator and echo width timer for an ultrasonic ranger.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per sample: the echo pin level and a flag
//   that marks one elapsed microsecond. Every accepted input transaction
//   produces exactly one result transaction on o_out: the trigger pin level,
//   the last echo width in microseconds (65535 until the first reading) and
//   a flag that is set in the transaction that completes a measurement.
//   i_cfg writes the trigger time, the timeout and the repeat gap by index;
//   it is always ready and should only be used while the core is idle.
//   A result is valid in the cycle after its input is accepted, and the core
//   sustains one transaction per cycle while the receiver does not stall. The
//   state update is a single pass of counter logic ahead of the result register.
//   When the receiver stalls, the result register holds its contents and
//   i_in.ready drops until the result is taken; a new input is accepted in
//   the same cycle the waiting result leaves.
//   Reset (synchronous, active low) restores the register defaults, puts the
//   core at trigger start with cleared counters and no reading, and empties
//   the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_core import uer_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    uer_cfg_if.sink   i_cfg,
    uer_in_if.sink    i_in,
    uer_out_if.source o_out
);

    t_cfg    cfg;
    t_result result;
    logic    accept;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Configuration register bank.
    uer_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // The input side is open whenever the result register is empty or is
    // being emptied in this cycle, so a stall never loses a result.
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Phase machine and counters; state advances only on an accepted sample.
    uer_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_tick       (i_in.tick),
        .i_echo_level (i_in.echo_level),
        .i_cfg        (cfg),
        .o_result     (result)
    );

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register needs no reset; it is qualified by r_valid.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.trigger_level = r_result.trigger_level;
    assign o_out.echo_time_us  = r_result.echo_time_us;
    assign o_out.new_reading   = r_result.new_reading;

    // Every accepted sample shows up as a valid result in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted transaction produced no result");

    // A completed measurement leaves the trigger low.
    a_done_trigger_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.new_reading |-> !o_out.trigger_level)
        else $error("trigger high in the transaction that completes a reading");

    // A fresh reading is never the no-reading code.
    a_done_has_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.new_reading |-> (o_out.echo_time_us != NO_READING))
        else $error("completed reading carries the no-reading code");

endmodule

`default_nettype wire

// ===== rtl/uer_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger configuration registers
// Holds the trigger time, timeout and repeat gap written over the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_cfg_regs import uer_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    uer_cfg_if.sink     i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken; an index beyond the list is dropped.
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_TRIGGER_TIME: n_cfg.trigger_time_us = i_cfg.data;
                CFG_TIMEOUT:      n_cfg.timeout_us      = i_cfg.data;
                CFG_REPEAT_GAP:   n_cfg.repeat_gap_us   = i_cfg.data;
                default:          n_cfg                 = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_time_us <= TRIGGER_TIME_RST;
            r_cfg.timeout_us      <= TIMEOUT_RST;
            r_cfg.repeat_gap_us   <= REPEAT_GAP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/uer_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger control
// Phase state machine with delay, timeout and echo width counters.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_ctrl import uer_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_tick,
    input  wire logic i_echo_level,
    input  wire t_cfg i_cfg,
    output t_result   o_result
);

    t_phase r_phase,         n_phase;
    t_timer r_delay_count,   n_delay_count;
    t_timer r_timeout_count, n_timeout_count;
    t_echo  r_width_count,   n_width_count;
    t_echo  r_last_reading,  n_last_reading;

    t_timer timeout_inc;
    t_echo  width_inc;
    logic   timed_out;
    logic   done;

    always_comb begin
        timeout_inc = (i_tick && (r_timeout_count != TIMER_MAX))
                    ? r_timeout_count + 1'b1 : r_timeout_count;
        width_inc   = (i_tick && (r_width_count < WIDTH_MAX))
                    ? r_width_count + 1'b1 : r_width_count;
        timed_out   = (r_phase != PH_TRIG_START)
                    && (32'(timeout_inc) > 32'(i_cfg.timeout_us));

        n_phase         = r_phase;
        n_delay_count   = r_delay_count;
        n_timeout_count = timeout_inc;
        n_width_count   = r_width_count;
        n_last_reading  = r_last_reading;
        done            = 1'b0;

        if (r_delay_count != '0) begin
            if (i_tick) begin
                n_delay_count = r_delay_count - 1'b1;
            end
        end else begin
            // A timeout restarts the trigger in this same transaction.
            case (timed_out ? PH_TRIG_START : r_phase)
                PH_TRIG_STOP: begin
                    n_phase = PH_WAIT_HIGH;
                end
                PH_WAIT_HIGH: begin
                    if (i_echo_level) begin
                        n_width_count = '0;
                        n_phase       = PH_WAIT_LOW;
                    end
                end
                PH_WAIT_LOW: begin
                    n_width_count = width_inc;
                    if (!i_echo_level) begin
                        n_last_reading = width_inc;
                        done           = 1'b1;
                        n_delay_count  = load_count(i_cfg.repeat_gap_us);
                        n_phase        = PH_TRIG_START;
                    end
                end
                default: begin
                    n_delay_count   = load_count(i_cfg.trigger_time_us);
                    n_timeout_count = '0;
                    n_phase         = PH_TRIG_STOP;
                end
            endcase
        end

        o_result.trigger_level = (n_phase == PH_TRIG_STOP);
        o_result.echo_time_us  = n_last_reading;
        o_result.new_reading   = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_TRIG_START;
            r_delay_count   <= '0;
            r_timeout_count <= '0;
            r_width_count   <= '0;
            r_last_reading  <= NO_READING;
        end else if (i_en) begin
            r_phase         <= n_phase;
            r_delay_count   <= n_delay_count;
            r_timeout_count <= n_timeout_count;
            r_width_count   <= n_width_count;
            r_last_reading  <= n_last_reading;
        end
    end

    // While a delay runs the phase must not move.
    a_delay_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (r_delay_count != '0) |=> $stable(r_phase))
        else $error("phase changed while a delay was running");

    // The echo width never reaches the no-reading code.
    a_width_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_width_count <= WIDTH_MAX)
        else $error("echo width counter passed its saturation value");

    // A completed measurement always loads the repeat gap into the delay.
    a_done_loads_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && done |=> (r_phase == PH_TRIG_START)
                         && (r_delay_count == load_count($past(i_cfg.repeat_gap_us))))
        else $error("completed measurement did not start the repeat gap");

endmodule

`default_nettype wire
